[hdl/sha1_stream_hasher_core_macros.svh]
// assertion macros for the sha1 stream hasher core
// used by the top level; expects signals clk and rst_n in scope
`ifndef SHA1_STREAM_HASHER_CORE_MACROS_SVH
`define SHA1_STREAM_HASHER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SHA1SH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha1 core check failed");

// next-cycle implication, checked outside reset
`define SHA1SH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha1 core check failed");

`endif

[hdl/sha1sh_pkg.sv]
// shared types and constants of the sha1 stream hasher core
// no dependencies
`timescale 1ns / 1ps

package sha1sh_pkg;

    typedef logic [31:0] word_t;

    localparam word_t H0 = 32'h67452301;
    localparam word_t H1 = 32'hEFCDAB89;
    localparam word_t H2 = 32'h98BADCFE;
    localparam word_t H3 = 32'h10325476;
    localparam word_t H4 = 32'hC3D2E1F0;

    localparam word_t K0 = 32'h5A827999;
    localparam word_t K1 = 32'h6ED9EBA1;
    localparam word_t K2 = 32'h8F1BBCDC;
    localparam word_t K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    localparam logic [6:0] ROUND_Q1   = 7'd20;
    localparam logic [6:0] ROUND_Q2   = 7'd40;
    localparam logic [6:0] ROUND_Q3   = 7'd60;
    localparam logic [6:0] ROUND_LAST = 7'd79;

    localparam logic [2:0] LAST_IDX = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic       push_in;   // take the input byte
        logic       push_pad;  // take the next padding byte
        logic       load;      // copy chain words into working registers
        logic       round;     // run one compression round
        logic       add;       // fold working registers into chain words
        logic       clear;     // back to initial state
        logic [2:0] out_idx;   // digest word to show
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic fill_last;   // the next byte completes a block
        logic round_last;  // this is round 79
        logic len_done;    // the block holding the bit count was filled
    } dp_stat_t;

endpackage

[hdl/sha1_stream_hasher_core.sv]
// top level of the sha1 stream hasher core: stream ports, controller and
// datapath; uses sha1sh_pkg, sha1sh_ctrl, sha1sh_dp and the assertion macros
`timescale 1ns / 1ps
`include "sha1_stream_hasher_core_macros.svh"

// SHA-1 over a byte stream. Each input item may carry one message byte
// (s_tuser high) and may end the message (s_tlast high). An item that
// carries no block-completing byte and does not end the message leaves the
// block ready for the next item. The byte that completes a 64-byte block
// starts a compression pass: a load step, 80 rounds through a single round
// unit at one round per clock, and an add step that folds the result into
// the chaining words; the block accepts no item meanwhile. On the final item
// the block pads on its own, one padding byte per clock up to the end of the
// block, then compresses (twice when more than 55 bytes of the last block
// are filled), and then presents the five digest words, most significant
// first, one per output handshake, the fifth marked by m_tlast. After the
// fifth word is taken the chaining words, byte and bit counters and padding
// flags return to their initial values for the next message. For long
// messages the one-round-per-clock compression loop sets the pace. No item
// is accepted while digest words are being presented.
module sha1_stream_hasher_core (
    input  logic        clk,
    input  logic        rst_n,
    // input item
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // is_final
    // result item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_tlast    // last_word
);

    sha1sh_pkg::dp_cmd_t  dp_cmd;
    sha1sh_pkg::dp_stat_t dp_stat;
    logic [31:0]          digest_word;
    logic [2:0]           word_index;

    sha1sh_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .has_byte   (s_tuser),
        .is_final   (s_tlast),
        .in_ready   (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_last   (m_tlast),
        .word_index (word_index),
        .stat       (dp_stat),
        .cmd        (dp_cmd)
    );

    sha1sh_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_in     (s_tdata),
        .cmd         (dp_cmd),
        .stat        (dp_stat),
        .digest_word (digest_word)
    );

    // digest word in the low bits, its position above, zero fill to 40 bits
    assign m_tdata = {5'b00000, word_index, digest_word};

    // input and output sides are never open together
    `SHA1SH_ASSERT_NOW(a_no_overlap, m_tvalid, !s_tready)

    // the fifth digest word taken puts the block back in idle
    `SHA1SH_ASSERT_NEXT(a_back_to_idle, m_tvalid && m_tready && m_tlast, s_tready && !m_tvalid)

    // an item with no byte that does not end the message leaves the block ready
    `SHA1SH_ASSERT_NEXT(a_empty_item, s_tvalid && s_tready && !s_tuser && !s_tlast, s_tready)

    // the word marked last is always the fifth one
    `SHA1SH_ASSERT_NOW(a_last_pos, m_tvalid && m_tlast, m_tdata[34:32] == sha1sh_pkg::LAST_IDX)

endmodule

[hdl/sha1sh_dp.sv]
// datapath of the sha1 stream hasher core: byte packing, schedule shift line,
// round unit, chain words, counters and padding source; uses sha1sh_pkg
`timescale 1ns / 1ps

module sha1sh_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          byte_in,
    input  sha1sh_pkg::dp_cmd_t cmd,
    output sha1sh_pkg::dp_stat_t stat,
    output logic [31:0]         digest_word
);

    logic [31:0] chain_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] w_reg [16];
    logic [23:0] part_reg;
    logic [5:0]  fill_reg;
    logic [63:0] bitcnt_reg;
    logic [6:0]  rnd_reg;
    logic        pad_started_reg;
    logic        len_ok_reg;
    logic        len_done_reg;

    logic [7:0]  pad_byte;
    logic [7:0]  byte_sel;
    logic        push;
    logic        word_push;
    logic [31:0] sched_mix;
    logic [31:0] sched_new;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] t_val;

    // padding: marker byte first, then zeros, bit count in the last 8 bytes
    always_comb
    begin
        if (!pad_started_reg)
            pad_byte = sha1sh_pkg::PAD_BYTE;
        else if (len_ok_reg && (fill_reg >= sha1sh_pkg::LEN_POS))
            pad_byte = bitcnt_reg[{~fill_reg[2:0], 3'b000} +: 8];
        else
            pad_byte = 8'h00;
    end

    assign byte_sel  = cmd.push_pad ? pad_byte : byte_in;
    assign push      = cmd.push_in | cmd.push_pad;
    assign word_push = push && (fill_reg[1:0] == 2'b11);

    assign sched_mix = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign sched_new = {sched_mix[30:0], sched_mix[31]};

    always_comb
    begin
        if (rnd_reg < sha1sh_pkg::ROUND_Q1)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1sh_pkg::K0;
        end
        else if (rnd_reg < sha1sh_pkg::ROUND_Q2)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1sh_pkg::K1;
        end
        else if (rnd_reg < sha1sh_pkg::ROUND_Q3)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1sh_pkg::K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1sh_pkg::K3;
        end
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_reg[0];

    // chain words, counters and padding flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0]    <= sha1sh_pkg::H0;
            chain_reg[1]    <= sha1sh_pkg::H1;
            chain_reg[2]    <= sha1sh_pkg::H2;
            chain_reg[3]    <= sha1sh_pkg::H3;
            chain_reg[4]    <= sha1sh_pkg::H4;
            fill_reg        <= '0;
            bitcnt_reg      <= '0;
            rnd_reg         <= '0;
            pad_started_reg <= 1'b0;
            len_ok_reg      <= 1'b0;
            len_done_reg    <= 1'b0;
        end
        else if (cmd.clear)
        begin
            chain_reg[0]    <= sha1sh_pkg::H0;
            chain_reg[1]    <= sha1sh_pkg::H1;
            chain_reg[2]    <= sha1sh_pkg::H2;
            chain_reg[3]    <= sha1sh_pkg::H3;
            chain_reg[4]    <= sha1sh_pkg::H4;
            fill_reg        <= '0;
            bitcnt_reg      <= '0;
            pad_started_reg <= 1'b0;
            len_ok_reg      <= 1'b0;
            len_done_reg    <= 1'b0;
        end
        else
        begin
            if (push)
                fill_reg <= fill_reg + 6'd1;
            if (cmd.push_in)
                bitcnt_reg <= bitcnt_reg + 64'd8;
            if (cmd.push_pad)
            begin
                pad_started_reg <= 1'b1;
                // a fresh block after the marker always has room for the count
                if (&fill_reg)
                begin
                    len_ok_reg   <= 1'b1;
                    len_done_reg <= len_ok_reg;
                end
                else if (!pad_started_reg && (fill_reg < sha1sh_pkg::LEN_POS))
                    len_ok_reg <= 1'b1;
            end
            if (cmd.load)
                rnd_reg <= '0;
            else if (cmd.round)
                rnd_reg <= rnd_reg + 7'd1;
            if (cmd.add)
            begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
                chain_reg[4] <= chain_reg[4] + e_reg;
            end
        end
    end

    // working registers and schedule shift line, word 0 is the current one
    always_ff @(posedge clk)
    begin
        if (push)
            part_reg <= {part_reg[15:0], byte_sel};
        if (word_push)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= {part_reg, byte_sel};
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= sched_new;
        end
        if (cmd.load)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (cmd.round)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    always_comb
    begin
        case (cmd.out_idx)
            3'd0:    digest_word = chain_reg[0];
            3'd1:    digest_word = chain_reg[1];
            3'd2:    digest_word = chain_reg[2];
            3'd3:    digest_word = chain_reg[3];
            3'd4:    digest_word = chain_reg[4];
            default: digest_word = chain_reg[4];
        endcase
    end

    assign stat.fill_last  = &fill_reg;
    assign stat.round_last = (rnd_reg == sha1sh_pkg::ROUND_LAST);
    assign stat.len_done   = len_done_reg;

endmodule

[hdl/sha1sh_ctrl.sv]
// controller of the sha1 stream hasher core: input handshake, block
// compression sequence, padding pass and digest output; uses sha1sh_pkg
`timescale 1ns / 1ps

module sha1sh_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 has_byte,
    input  logic                 is_final,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_last,
    output logic [2:0]           word_index,
    input  sha1sh_pkg::dp_stat_t stat,
    output sha1sh_pkg::dp_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LOAD  = 6'b000010,
        ST_ROUND = 6'b000100,
        ST_ADD   = 6'b001000,
        ST_PAD   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic       fin_reg, fin_next;
    logic [2:0] idx_reg, idx_next;
    logic       accept;

    assign accept = in_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        fin_next     = fin_reg;
        idx_next     = idx_reg;
        cmd          = '0;
        cmd.out_idx  = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.push_in = has_byte;
                    fin_next    = is_final;
                    if (has_byte && stat.fill_last)
                        state_next = ST_LOAD;
                    else if (is_final)
                        state_next = ST_PAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (stat.round_last)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add = 1'b1;
                if (!fin_reg)
                    state_next = ST_IDLE;
                else if (stat.len_done)
                    state_next = ST_OUT;
                else
                    state_next = ST_PAD;
            end
            ST_PAD:
            begin
                cmd.push_pad = 1'b1;
                if (stat.fill_last)
                    state_next = ST_LOAD;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (idx_reg == sha1sh_pkg::LAST_IDX)
                    begin
                        cmd.clear  = 1'b1;
                        fin_next   = 1'b0;
                        idx_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                        idx_next = idx_reg + 3'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fin_reg   <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            idx_reg   <= idx_next;
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = (state_reg == ST_OUT);
    assign out_last   = (idx_reg == sha1sh_pkg::LAST_IDX);
    assign word_index = idx_reg;

endmodule

[tb/sv/tb_sha1_stream_hasher_core.sv]
// testbench for the sha1 stream hasher core: directed and random messages,
// digest words checked against an in-bench sha-1 predictor
// depends on sha1sh_pkg and sha1_stream_hasher_core
`timescale 1ns / 1ps

module tb_sha1_stream_hasher_core;

    // run shape
    localparam int ITEM_TARGET  = 370;   // input items over the whole run
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off to back up the core
    localparam int DRAIN_CYCLES = 400;   // extra wait after the last expected digest word is taken

    // well-known digests, readable without running anything
    localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
    localparam logic [159:0] ABC_DIGEST   = 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

    // one row of directed stimulus; known marks a typed-in digest
    typedef struct packed {
        logic [159:0] digest;
        logic         known;
        logic         fin;
        logic         has;
        logic [7:0]   data;
    } stim_row_t;

    // one expected digest word
    typedef struct {
        sha1sh_pkg::word_t word;
        logic [2:0]        idx;
        logic              last;
    } digest_word_t;

    localparam int DIRECTED_ROWS = 11;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // empty message: final with no byte
        '{EMPTY_DIGEST, 1'b1, 1'b1, 1'b0, 8'h00},
        // "abc" with the final riding on the last byte
        '{160'h0,       1'b0, 1'b0, 1'b1, 8'h61},
        '{160'h0,       1'b0, 1'b0, 1'b1, 8'h62},
        '{ABC_DIGEST,   1'b1, 1'b1, 1'b1, 8'h63},
        // item with no byte and no final is ignored
        '{160'h0,       1'b0, 1'b0, 1'b0, 8'hff},
        // byte extremes, byte and final together
        '{160'h0,       1'b0, 1'b0, 1'b1, 8'hff},
        '{160'h0,       1'b0, 1'b1, 1'b1, 8'h00},
        // final as a separate item, data ignored
        '{160'h0,       1'b0, 1'b0, 1'b1, 8'h00},
        '{160'h0,       1'b0, 1'b1, 1'b0, 8'ha5},
        // one-byte messages at both extremes
        '{160'h0,       1'b0, 1'b1, 1'b1, 8'hff},
        '{160'h0,       1'b0, 1'b1, 1'b1, 8'h00}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tuser;   // [0] has_byte
    logic        s_tlast;   // is_final
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [31:0] digest_word, [34:32] word_index, rest zero
    logic        m_tlast;   // last_word

    sha1_stream_hasher_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // sha-1 predictor: its own chaining words, block buffer and length
    // ------------------------------------------------------------------
    sha1sh_pkg::word_t chain_h [5];
    logic [7:0]        msg_block [64];
    int                block_fill;
    logic [63:0]       msg_bits;
    digest_word_t      digest_q [$];

    int  fail_count = 0;
    int  items_sent = 0;
    bit  hold_req = 1'b0;

    function automatic sha1sh_pkg::word_t rotl(sha1sh_pkg::word_t v, int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    task automatic clear_hash_state();
        chain_h[0] = sha1sh_pkg::H0;
        chain_h[1] = sha1sh_pkg::H1;
        chain_h[2] = sha1sh_pkg::H2;
        chain_h[3] = sha1sh_pkg::H3;
        chain_h[4] = sha1sh_pkg::H4;
        block_fill = 0;
        msg_bits   = 64'd0;
    endtask

    // full 80-round compression of msg_block into chain_h
    task automatic compress_block_pred();
        sha1sh_pkg::word_t w [80];
        sha1sh_pkg::word_t a, b, c, d, e, f, k, t;
        for (int j = 0; j < 16; j++)
        begin
            w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
        end
        for (int j = 16; j < 80; j++)
        begin
            w[j] = rotl(w[j-3] ^ w[j-8] ^ w[j-14] ^ w[j-16], 1);
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = sha1sh_pkg::K0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = sha1sh_pkg::K1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1sh_pkg::K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = sha1sh_pkg::K3;
            end
            t = rotl(a, 5) + f + e + k + w[r];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endtask

    // advance the predictor by one accepted item; on a final item queue the
    // five digest words (typed-in ones where the row carries them)
    task automatic absorb_item(logic [7:0] data, logic has, logic fin,
                               logic known, logic [159:0] known_digest);
        logic [159:0] digest;
        digest_word_t dw;
        if (has)
        begin
            msg_block[block_fill] = data;
            block_fill++;
            msg_bits += 64'd8;
            if (block_fill == 64)
            begin
                compress_block_pred();
                block_fill = 0;
            end
        end
        if (fin)
        begin
            msg_block[block_fill] = sha1sh_pkg::PAD_BYTE;
            block_fill++;
            // no room left for the length: pad out and spill into an extra block
            if (block_fill > int'(sha1sh_pkg::LEN_POS))
            begin
                for (int i = block_fill; i < 64; i++)
                    msg_block[i] = 8'h00;
                compress_block_pred();
                block_fill = 0;
            end
            for (int i = block_fill; i < int'(sha1sh_pkg::LEN_POS); i++)
                msg_block[i] = 8'h00;
            for (int i = 0; i < 8; i++)
                msg_block[int'(sha1sh_pkg::LEN_POS) + i] = msg_bits[63 - 8*i -: 8];
            compress_block_pred();
            digest = {chain_h[0], chain_h[1], chain_h[2], chain_h[3], chain_h[4]};
            if (known)
                digest = known_digest;
            for (int i = 0; i < 5; i++)
            begin
                dw.word = digest[159 - 32*i -: 32];
                dw.idx  = 3'(i);
                dw.last = (3'(i) == sha1sh_pkg::LAST_IDX);
                digest_q.push_back(dw);
            end
            clear_hash_state();
        end
    endtask

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(12, 50);
    endfunction

    // offer one item, wait for its handshake, then feed the predictor
    task automatic send_item(logic [7:0] data, logic has, logic fin, bit gaps_on,
                             logic known, logic [159:0] known_digest);
        int gap;
        gap = gaps_on ? idle_len() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= has;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        absorb_item(data, has, fin, known, known_digest);
        items_sent++;
    endtask

    // message lengths cluster around the padding and block boundaries
    function automatic int pick_length();
        int lengths [12] = '{0, 1, 54, 55, 56, 57, 63, 64, 65, 119, 120, 128};
        if ($urandom_range(0, 2) == 0)
            return lengths[$urandom_range(0, 11)];
        return $urandom_range(0, 24);
    endfunction

    // one random message, with stray ignored items mixed in
    task automatic send_message(int len, bit gaps_on);
        bit merge_final;
        merge_final = (len > 0) && $urandom_range(0, 1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom), 1'b0, 1'b0, gaps_on, 1'b0, 160'h0);
            send_item(8'($urandom), 1'b1, merge_final && (i == len - 1), gaps_on,
                      1'b0, 160'h0);
        end
        if (!merge_final)
            send_item(8'($urandom), 1'b0, 1'b1, gaps_on, 1'b0, 160'h0);
    endtask

    initial
    begin
        int len;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        rst_n    = 1'b0;
        clear_hash_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_item(DIRECTED[i].data, DIRECTED[i].has, DIRECTED[i].fin, 1'b1,
                      DIRECTED[i].known, DIRECTED[i].digest);
        end

        // ask the receiver for one long hold-off; the next digest then
        // backs up inside the core and stalls the input side
        hold_req = 1'b1;

        // random part; roughly a quarter of the messages go back to back
        while (items_sent < ITEM_TARGET)
        begin
            len = pick_length();
            if (len > ITEM_TARGET - items_sent)
                len = ITEM_TARGET - items_sent;
            send_message(len, $urandom_range(0, 3) != 0);
        end

        s_tvalid <= 1'b0;
        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[sha1_stream_hasher_core] OK");
        else
            $display("[sha1_stream_hasher_core] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver side: random stalls, ready stretches, one long hold-off
    // ------------------------------------------------------------------
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                // hold off from the first waiting digest word on
                hold_req = 1'b0;
                m_tready <= 1'b0;
                @(posedge clk);
                while (!m_tvalid)
                    @(posedge clk);
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                // stretch with no stalls at all
                m_tready <= 1'b1;
                repeat ($urandom_range(20, 120)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                m_tready <= 1'b0;
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(15, 60)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 4)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // digest word checker: every accepted word against the oldest expected
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        digest_word_t exp_w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (digest_q.size() == 0)
            begin
                $error("unexpected digest item: data %h last %b", m_tdata, m_tlast);
                fail_count++;
            end
            else
            begin
                exp_w = digest_q.pop_front();
                if (m_tdata[31:0] !== exp_w.word)
                begin
                    $error("digest_word mismatch: expected %h, got %h",
                           exp_w.word, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[34:32] !== exp_w.idx)
                begin
                    $error("word_index mismatch: expected %0d, got %0d",
                           exp_w.idx, m_tdata[34:32]);
                    fail_count++;
                end
                if (m_tlast !== exp_w.last)
                begin
                    $error("last_word mismatch: expected %b, got %b", exp_w.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("[sha1_stream_hasher_core] ERROR");
        $finish;
    end

endmodule

[sha1_stream_hasher_core.f]
+incdir+hdl
hdl/sha1sh_pkg.sv
hdl/sha1sh_dp.sv
hdl/sha1sh_ctrl.sv
hdl/sha1_stream_hasher_core.sv
tb/sv/tb_sha1_stream_hasher_core.sv
